>>> rtl/tcr_pkg.sv
`default_nettype none
package tcr_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int LINE_BYTES = 320;
  localparam int TOP_MARGIN = 40;

  localparam int SCAN_LINES = 16;
  localparam int PLANES     = 4;
  localparam int OFF_W      = 18;
  localparam int FONT_AW    = 11;
  localparam int CFG_IDX_W  = 1;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_DRAW = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_READY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FONT_PRESENT = 1'b1;

  localparam logic [7:0] H8 = 8'hFF;
  localparam logic [7:0] V8 = 8'h18;

  typedef enum logic [1:0] {
    SRC_FIXED,
    SRC_FONT,
    SRC_MARKER
  } glyph_src_t;

  typedef struct packed {
    logic [OFF_W-1:0] off;
    logic [6:0]       base;
    logic             inv;
    glyph_src_t       src;
    logic [6:0]       ascii;
    logic [3:0]       colour;
  } cell_t;

  typedef struct packed {
    logic       active;
    logic       last_issue;
    logic       font_busy;
    logic [6:0] ascii;
  } eng_status_t;

  typedef struct packed {
    logic [OFF_W-1:0] offset;
    logic [7:0]       value;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic [1:0] count;
    logic       pop;
  } q_status_t;

  function automatic logic fixed_hit(input logic [6:0] base);
    fixed_hit = base inside {7'd30, 7'd31, 7'd32, 7'd64, 7'd81, 7'd91, 7'd93, 7'd98,
                             7'd100, 7'd107, 7'd109, 7'd110, 7'd112, 7'd113, 7'd114,
                             7'd115, 7'd125};
  endfunction

  // top rows 0..6, crossbar rows 7..8, bottom rows 9..15
  function automatic logic [7:0] box_row(input logic [7:0] top, input logic [7:0] mid,
                                         input logic [7:0] bot, input logic [3:0] r);
    if (r < 4'd7) begin
      box_row = top;
    end else if (r < 4'd9) begin
      box_row = mid;
    end else begin
      box_row = bot;
    end
  endfunction

  function automatic logic [7:0] fixed_row(input logic [6:0] base, input logic [3:0] r);
    fixed_row = 8'h00;
    case (base)
      7'd64:   fixed_row = box_row(8'h00, H8, 8'h00, r);
      7'd93:   fixed_row = V8;
      7'd112:  fixed_row = box_row(8'h00, 8'h1F, V8, r);
      7'd110:  fixed_row = box_row(8'h00, 8'hF8, V8, r);
      7'd109:  fixed_row = box_row(V8, 8'h1F, 8'h00, r);
      7'd125:  fixed_row = box_row(V8, 8'hF8, 8'h00, r);
      7'd107:  fixed_row = box_row(V8, 8'h1F, V8, r);
      7'd115:  fixed_row = box_row(V8, 8'hF8, V8, r);
      7'd114:  fixed_row = box_row(8'h00, H8, V8, r);
      7'd113:  fixed_row = box_row(V8, H8, 8'h00, r);
      7'd91:   fixed_row = box_row(V8, H8, V8, r);
      7'd98:   fixed_row = (r < 4'd8) ? 8'h00 : H8;
      7'd100:  fixed_row = (r == 4'd15) ? H8 : 8'h00;
      7'd30: begin
        case (r)
          4'd2:    fixed_row = 8'h18;
          4'd3:    fixed_row = 8'h3C;
          4'd4:    fixed_row = 8'h7E;
          4'd5:    fixed_row = 8'hFF;
          default: fixed_row = (r >= 4'd6 && r <= 4'd12) ? 8'h18 : 8'h00;
        endcase
      end
      7'd31: begin
        case (r)
          4'd3, 4'd10: fixed_row = 8'h10;
          4'd4, 4'd9:  fixed_row = 8'h30;
          4'd5, 4'd8:  fixed_row = 8'h7E;
          4'd6, 4'd7:  fixed_row = 8'hFF;
          default:     fixed_row = 8'h00;
        endcase
      end
      7'd81: begin
        case (r)
          4'd4, 4'd10:      fixed_row = 8'h3C;
          4'd5, 4'd9:       fixed_row = 8'h7E;
          4'd6, 4'd7, 4'd8: fixed_row = 8'hFF;
          default:          fixed_row = 8'h00;
        endcase
      end
      default: fixed_row = 8'h00;
    endcase
  endfunction

  function automatic logic ascii_ok(input logic [6:0] base);
    ascii_ok = base inside {[7'd0:7'd27], 7'd29, [7'd32:7'd63]};
  endfunction

  // codes below 32 land on '@'..'_' (64..95) by adding 64
  function automatic logic [6:0] ascii_of(input logic [6:0] base);
    ascii_of = (base < 7'd32) ? base + 7'd64 : base;
  endfunction

  function automatic logic [7:0] marker_row(input logic [3:0] r);
    marker_row = (r == 4'd0 || r == 4'd15) ? 8'hFF : 8'h81;
  endfunction

endpackage
`default_nettype wire

>>> rtl/tcr_font_mem.sv
`default_nettype none
module tcr_font_mem (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [tcr_pkg::FONT_AW-1:0] wr_addr,
  input  wire logic [7:0]                  wr_data,
  input  wire logic [tcr_pkg::FONT_AW-1:0] rd_addr,
  output logic      [7:0]                  rd_data
);
  import tcr_pkg::*;

  logic [7:0] mem [2**FONT_AW];

  // read returns the old entry on a same-address write
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule
`default_nettype wire

>>> rtl/tcr_out_queue.sv
`default_nettype none
module tcr_out_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire tcr_pkg::out_item_t   push_item,
  input  wire logic                 out_stall,
  output logic                      out_valid,
  output tcr_pkg::out_item_t        out_item,
  output tcr_pkg::q_status_t        status
);
  import tcr_pkg::*;

  out_item_t  entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign out_valid    = (count != 2'd0);
  assign pop          = out_valid & ~out_stall;
  assign out_item     = entries[rd_ptr];
  assign status.count = count;
  assign status.pop   = pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule
`default_nettype wire

>>> rtl/tcr_cell_engine.sv
`default_nettype none
module tcr_cell_engine (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire tcr_pkg::cell_t              cell_in,
  input  wire tcr_pkg::q_status_t          q,
  output logic      [tcr_pkg::FONT_AW-1:0] rd_addr,
  input  wire logic [7:0]                  rd_data,
  output logic                             push,
  output tcr_pkg::out_item_t               push_item,
  output tcr_pkg::eng_status_t             status
);
  import tcr_pkg::*;

  localparam int KW = $clog2(SCAN_LINES * PLANES);
  localparam int RW = $clog2(SCAN_LINES);
  localparam int PW = $clog2(PLANES);
  localparam logic [KW-1:0]    K_LAST  = KW'(SCAN_LINES * PLANES - 1);
  localparam logic [PW-1:0]    P_LAST  = PW'(PLANES - 1);
  localparam logic [OFF_W-1:0] LINE_W  = OFF_W'(LINE_BYTES);

  cell_t            cur;
  logic             active;
  logic [KW-1:0]    k;
  logic [OFF_W-1:0] row_off;
  logic             issue;
  logic [2:0]       occ;

  // write stage, registered at issue so it lines up with the font read
  logic             inflight;
  logic [OFF_W-1:0] s_off;
  logic [RW-1:0]    s_row;
  logic             s_last;
  logic             s_en;
  logic             s_inv;
  glyph_src_t       s_src;
  logic [6:0]       s_base;
  logic [7:0]       glyph;

  // issue only if the queue can still take it after what is in flight lands
  assign occ     = {1'b0, q.count} + {2'b00, inflight};
  assign issue   = active & (occ <= {2'b00, q.pop} + 3'd1);
  assign rd_addr = {cur.ascii, k[KW-1:PW]};

  assign status.active     = active;
  assign status.last_issue = issue & (k == K_LAST);
  assign status.font_busy  = active & (cur.src == SRC_FONT);
  assign status.ascii      = cur.ascii;

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      inflight <= 1'b0;
      k        <= '0;
    end else begin
      inflight <= issue;
      if (start) begin
        active <= 1'b1;
        k      <= '0;
      end else if (issue) begin
        k <= k + KW'(1);
        if (k == K_LAST) begin
          active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s_off  <= row_off + OFF_W'({k[PW-1:0], 1'b0});
      s_row  <= k[KW-1:PW];
      s_last <= (k == K_LAST);
      s_en   <= cur.colour[k[PW-1:0]];
      s_inv  <= cur.inv;
      s_src  <= cur.src;
      s_base <= cur.base;
    end
    if (start) begin
      cur     <= cell_in;
      row_off <= cell_in.off;
    end else if (issue && (k[PW-1:0] == P_LAST)) begin
      row_off <= row_off + LINE_W;
    end
  end

  always_comb begin
    case (s_src)
      SRC_FIXED: glyph = fixed_row(s_base, s_row);
      SRC_FONT:  glyph = rd_data;
      default:   glyph = marker_row(s_row);
    endcase
  end

  assign push             = inflight;
  assign push_item.offset = s_off;
  assign push_item.value  = s_en ? (s_inv ? ~glyph : glyph) : 8'h00;
  assign push_item.last   = s_last;

endmodule
`default_nettype wire

>>> rtl/text_cell_planar_renderer.sv
`default_nettype none
// channel  direction  handshake            payload
// in       input      in_valid / in_stall  mode, column, cell_row, screen_code, colour,
//                                          font_char, font_line, font_bits
// out      output     out_valid/out_stall  byte_offset, byte_value, last
// cfg      input      cfg_we               cfg_index, cfg_data
//
// A drawn cell gives 64 writes at one per cycle while out_stall is low, paced by the
// two-entry output queue. The first write passes the cell and write-stage registers
// and the output queue. The next draw is taken in the cycle the current cell issues
// its last write. A load stalls while the active cell still reads the same glyph from
// the font memory. Reset clears config and control state, not datapath or font memory.
module text_cell_planar_renderer (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [tcr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic                          cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          mode,
  input  wire logic [7:0]                    column,
  input  wire logic [7:0]                    cell_row,
  input  wire logic [7:0]                    screen_code,
  input  wire logic [3:0]                    colour,
  input  wire logic [6:0]                    font_char,
  input  wire logic [3:0]                    font_line,
  input  wire logic [7:0]                    font_bits,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [tcr_pkg::OFF_W-1:0]     byte_offset,
  output logic      [7:0]                    byte_value,
  output logic                               last
);
  import tcr_pkg::*;

  localparam logic [OFF_W-1:0] LINE_W = OFF_W'(LINE_BYTES);

  logic                screen_ready;
  logic                font_present;
  logic                accept;
  logic                load;
  logic                start;
  logic [6:0]          base;
  logic [OFF_W-1:0]    line;
  logic [OFF_W-1:0]    line_off;
  cell_t               desc;
  eng_status_t         eng;
  q_status_t           q;
  logic [FONT_AW-1:0]  rd_addr;
  logic [7:0]          rd_data;
  logic                push;
  out_item_t           push_item;
  out_item_t           out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_ready <= 1'b0;
      font_present <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCREEN_READY: screen_ready <= cfg_data;
        CFG_FONT_PRESENT: font_present <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (mode == MODE_DRAW) begin
      in_stall = eng.active & ~eng.last_issue;
    end else begin
      in_stall = eng.font_busy & (font_char == eng.ascii);
    end
  end

  assign accept = in_valid & ~in_stall;
  assign load   = accept & (mode == MODE_LOAD);
  assign start  = accept & (mode == MODE_DRAW) & screen_ready
                & (column < 8'(COLUMNS)) & (cell_row < 8'(ROWS));

  assign base     = screen_code[6:0];
  assign line     = OFF_W'(TOP_MARGIN) + OFF_W'({cell_row, 4'b0000});
  assign line_off = line * LINE_W;

  always_comb begin
    desc.off    = line_off + OFF_W'({column[7:1], 2'b00, column[0]});
    desc.base   = base;
    desc.inv    = screen_code[7];
    desc.ascii  = ascii_of(base);
    desc.colour = colour;
    if (fixed_hit(base)) begin
      desc.src = SRC_FIXED;
    end else if (ascii_ok(base) && font_present) begin
      desc.src = SRC_FONT;
    end else begin
      desc.src = SRC_MARKER;
    end
  end

  tcr_font_mem u_font (
    .clk     (clk),
    .we      (load),
    .wr_addr ({font_char, font_line}),
    .wr_data (font_bits),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tcr_cell_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cell_in   (desc),
    .q         (q),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .push      (push),
    .push_item (push_item),
    .status    (eng)
  );

  tcr_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .status    (q)
  );

  assign byte_offset = out_item.offset;
  assign byte_value  = out_item.value;
  assign last        = out_item.last;

endmodule
`default_nettype wire
